// File: rtl/tlpq_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tlpq_pkg: shared definitions for the three-level priority queue
// Sizes, operation and status codes, and the structs that run between the
// sequencer, the tag store and the top level.
// ---------------------------------------------------------------------------
package tlpq_pkg;

    localparam int LEVEL_DEPTH = 16;
    localparam int TAG_BITS    = 32;
    localparam int NUM_LEVELS  = 3;

    localparam int STORE_SIZE = NUM_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int IDX_W      = $clog2(LEVEL_DEPTH);
    localparam int CNT_W      = $clog2(LEVEL_DEPTH + 1);
    localparam int RING_W     = $clog2(NUM_LEVELS);
    localparam int OP_W       = 2;
    localparam int LVL_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT     = 2'd0,
        OP_REMOVE     = 2'd1,
        OP_LIST_LEVEL = 2'd2,
        OP_LIST_ALL   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NO_ENTRY = 2'd3
    } status_t;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [LVL_W-1:0]    level;
        status_t             status;
        logic                last;
    } res_t;

    typedef struct packed {
        logic                wr_en;
        logic                rd_en;
        logic [ADDR_W-1:0]   addr;
        logic [TAG_BITS-1:0] wr_data;
    } mem_req_t;

endpackage
`default_nettype wire

// File: rtl/tlpq_store.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tlpq_store: tag memory
// One write and one read per cycle; read data is registered. The rings of
// all levels share this single array.
// ---------------------------------------------------------------------------
module tlpq_store
    import tlpq_pkg::*;
(
    input  wire logic                aclk,
    input  wire mem_req_t            mem_req,
    output logic [TAG_BITS-1:0]      rd_data
);

    logic [TAG_BITS-1:0] mem [STORE_SIZE];
    logic [TAG_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            mem[mem_req.addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en) begin
            rd_data_reg <= mem[mem_req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: rtl/tlpq_seq.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tlpq_seq: queue sequencer
// Holds the head pointer and fill count of each level ring and steps one
// shared slot-address unit through inserts, removes and listings.
// ---------------------------------------------------------------------------
module tlpq_seq
    import tlpq_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [OP_W-1:0]     in_operation,
    input  wire logic [TAG_BITS-1:0] in_tag,
    input  wire logic [LVL_W-1:0]    in_level,
    input  wire logic                out_free,
    output logic                     res_load,
    output res_t                     res,
    output mem_req_t                 mem_req,
    input  wire logic [TAG_BITS-1:0] rd_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [RING_W-1:0]   ring_reg, ring_next;
    logic [RING_W-1:0]   cur_reg, cur_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic [IDX_W-1:0]    head_reg  [NUM_LEVELS];
    logic [IDX_W-1:0]    head_next [NUM_LEVELS];
    logic [CNT_W-1:0]    count_reg  [NUM_LEVELS];
    logic [CNT_W-1:0]    count_next [NUM_LEVELS];

    logic                total_empty;
    logic                lower_any;
    logic [RING_W-1:0]   hi_ring;
    logic [RING_W-1:0]   next_ring;
    logic [RING_W-1:0]   sel_ring;
    logic [IDX_W-1:0]    sel_k;
    logic [IDX_W:0]      pos_sum;
    logic [IDX_W-1:0]    pos;
    logic [ADDR_W-1:0]   slot_addr;
    logic [LVL_W-1:0]    ring_lvl;
    logic [LVL_W-1:0]    cur_lvl;
    logic [CNT_W-1:0]    cur_cnt;
    logic                end_of_ring;
    logic [IDX_W-1:0]    head_inc;

    // Level 0 and levels above the ring count fold onto the lowest ring.
    function automatic logic [RING_W-1:0] ring_of(input logic [LVL_W-1:0] lvl);
        logic [RING_W-1:0] r;
        r = '0;
        if (lvl >= LVL_W'(2) && lvl <= LVL_W'(NUM_LEVELS)) begin
            r = RING_W'(lvl - LVL_W'(1));
        end
        return r;
    endfunction

    // Highest non-empty ring overall, and highest non-empty ring below the
    // one being listed.
    always_comb begin
        total_empty = 1'b1;
        lower_any   = 1'b0;
        hi_ring     = '0;
        next_ring   = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (count_reg[i] != '0) begin
                total_empty = 1'b0;
                hi_ring     = RING_W'(i);
                if (i < int'(cur_reg)) begin
                    lower_any = 1'b1;
                    next_ring = RING_W'(i);
                end
            end
        end
    end

    // Shared slot-address unit: ring base plus (head + offset) modulo depth.
    always_comb begin
        sel_ring  = (state_reg == S_EXEC) ? ring_reg : cur_reg;
        sel_k     = (state_reg == S_EXEC) ? IDX_W'(count_reg[ring_reg]) : k_reg;
        pos_sum   = {1'b0, head_reg[sel_ring]} + {1'b0, sel_k};
        pos       = (pos_sum >= (IDX_W+1)'(LEVEL_DEPTH))
                    ? IDX_W'(pos_sum - (IDX_W+1)'(LEVEL_DEPTH)) : IDX_W'(pos_sum);
        slot_addr = ADDR_W'(sel_ring) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(pos);
    end

    assign ring_lvl    = LVL_W'(ring_reg) + LVL_W'(1);
    assign cur_lvl     = LVL_W'(cur_reg) + LVL_W'(1);
    assign cur_cnt     = count_reg[cur_reg];
    assign end_of_ring = (CNT_W'(k_reg) + CNT_W'(1)) == cur_cnt;
    assign head_inc    = (head_reg[cur_reg] == IDX_W'(LEVEL_DEPTH - 1))
                         ? '0 : head_reg[cur_reg] + IDX_W'(1);
    assign s_ready     = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        tag_next   = tag_reg;
        ring_next  = ring_reg;
        cur_next   = cur_reg;
        k_next     = k_reg;
        head_next  = head_reg;
        count_next = count_reg;
        res_load   = 1'b0;
        res        = '0;
        mem_req         = '0;
        mem_req.addr    = slot_addr;
        mem_req.wr_data = tag_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = op_t'(in_operation);
                    tag_next   = in_tag;
                    ring_next  = ring_of(in_level);
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (op_reg == OP_INSERT) begin
                    if (out_free) begin
                        res_load   = 1'b1;
                        res.level  = ring_lvl;
                        res.last   = 1'b1;
                        state_next = S_IDLE;
                        if (count_reg[ring_reg] == CNT_W'(LEVEL_DEPTH)) begin
                            res.status = ST_FULL;
                        end else begin
                            res.status          = ST_OK;
                            mem_req.wr_en       = 1'b1;
                            count_next[ring_reg] = count_reg[ring_reg] + CNT_W'(1);
                        end
                    end
                end else if (total_empty) begin
                    if (out_free) begin
                        res_load   = 1'b1;
                        res.status = ST_EMPTY;
                        res.level  = (op_reg == OP_LIST_LEVEL) ? ring_lvl : '0;
                        res.last   = 1'b1;
                        state_next = S_IDLE;
                    end
                end else if (op_reg == OP_LIST_LEVEL && count_reg[ring_reg] == '0) begin
                    if (out_free) begin
                        res_load   = 1'b1;
                        res.status = ST_NO_ENTRY;
                        res.level  = ring_lvl;
                        res.last   = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    cur_next   = (op_reg == OP_LIST_LEVEL) ? ring_reg : hi_ring;
                    k_next     = '0;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                mem_req.rd_en = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    res.tag    = rd_data;
                    res.level  = cur_lvl;
                    res.status = ST_OK;
                    if (op_reg == OP_REMOVE) begin
                        res.last            = 1'b1;
                        head_next[cur_reg]  = head_inc;
                        count_next[cur_reg] = cur_cnt - CNT_W'(1);
                        state_next          = S_IDLE;
                    end else if (end_of_ring &&
                                 (op_reg == OP_LIST_LEVEL || !lower_any)) begin
                        res.last   = 1'b1;
                        state_next = S_IDLE;
                    end else if (end_of_ring) begin
                        cur_next   = next_ring;
                        k_next     = '0;
                        state_next = S_READ;
                    end else begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        tag_reg  <= tag_next;
        ring_reg <= ring_next;
        cur_reg  <= cur_next;
        k_reg    <= k_next;
    end

endmodule
`default_nettype wire

// File: rtl/three_level_priority_queue.sv
// Flow: insert and status-only results are set in the execute state and pass
// through the result stage; each removed or listed tag passes through a read
// state, a registered store access and an emit state before the result stage.
// No new input beat is taken until the last result of the current one is
// loaded; the sequencer steps one slot at a time. A held result beat stalls it.
// Reset: synchronous, active low; clears ring heads and counts. The tag store
// is not cleared, and the block is ready in the first cycle after reset.
`default_nettype none
// ---------------------------------------------------------------------------
// three_level_priority_queue: strict three-level priority queue
// FIFO rings per level in one shared tag store, served from level 3 down,
// with a registered result stage on the output channel.
// ---------------------------------------------------------------------------
module three_level_priority_queue
    import tlpq_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [OP_W-1:0]     s_operation,
    input  wire logic [TAG_BITS-1:0] s_entry_tag,
    input  wire logic [LVL_W-1:0]    s_level,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [TAG_BITS-1:0]      m_out_tag,
    output logic [LVL_W-1:0]         m_out_level,
    output logic [1:0]               m_status,
    output logic                     m_last
);

    logic                res_load;
    res_t                res;
    mem_req_t            mem_req;
    logic [TAG_BITS-1:0] rd_data;
    logic                out_free;
    logic                m_valid_reg;
    res_t                out_reg;

    assign out_free = !m_valid_reg || m_ready;

    tlpq_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .in_operation (s_operation),
        .in_tag       (s_entry_tag),
        .in_level     (s_level),
        .out_free     (out_free),
        .res_load     (res_load),
        .res          (res),
        .mem_req      (mem_req),
        .rd_data      (rd_data)
    );

    tlpq_store u_store (
        .aclk    (aclk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            out_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_tag   = out_reg.tag;
    assign m_out_level = out_reg.level;
    assign m_status    = out_reg.status;
    assign m_last      = out_reg.last;

`ifndef NO_ASSERTIONS
    // The sequencer must never overwrite a result beat that is still held.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> (!m_valid_reg || m_ready))
        else $error("result register loaded while a beat was pending");

    // An accepted beat keeps the sequencer busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted twice in a row");

    // Every status-only result closes its input beat.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> m_last)
        else $error("status result without last");

    // Successful results always name a real level.
    a_ok_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_OK) |-> (m_out_level != '0))
        else $error("ok result with level zero");
`endif

endmodule
`default_nettype wire
